[hdl/tmcr_pkg.sv]
// Shared types, constants and helpers for the text mode character renderer.
// No dependencies; every other file of the block uses it.
package tmcr_pkg;

    localparam int TEXT_COLS_DEF          = 90;
    localparam int TEXT_ROWS_DEF          = 40;
    localparam int GLYPH_LINES_DEF        = 16;
    localparam int OUTPUT_PIXEL_LIMIT_DEF = 345600;

    localparam int CELL_WIDTH = 8;
    localparam int FONT_DEPTH = 4096;
    localparam int FONT_AW    = 12;
    localparam int ADDR_W     = 12;
    localparam int SKIP_W     = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int PIXELS_W   = 32;
    localparam int COUNT_W    = 4;

    localparam logic [SKIP_W-1:0] SCROLL_SKIP_RST  = '0;
    localparam logic [7:0]        CURSOR_COL_RST   = 8'd1;
    localparam logic [7:0]        CURSOR_ROW_RST   = 8'd1;
    localparam logic [7:0]        CURSOR_FIRST_RST = 8'd14;
    localparam logic [7:0]        CURSOR_LAST_RST  = 8'd15;
    localparam logic [7:0]        BLINK_FACTOR_RST = 8'd16;

    typedef enum logic [1:0] {
        MODE_FONT_WR   = 2'd0,
        MODE_SCREEN_WR = 2'd1,
        MODE_FRAME     = 2'd2,
        MODE_RENDER    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCROLL_SKIP  = 3'd0,
        CFG_CURSOR_COL   = 3'd1,
        CFG_CURSOR_ROW   = 3'd2,
        CFG_CURSOR_FIRST = 3'd3,
        CFG_CURSOR_LAST  = 3'd4,
        CFG_BLINK_FACTOR = 3'd5
    } cfg_index_t;

    typedef struct packed {
        mode_t              mode;
        logic               cursor_here;
        logic [2:0]         start;
        logic [COUNT_W-1:0] count;
        logic               frame_done;
        logic               clear_pending;
    } pix_ctrl_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[hdl/tmcr_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on tmcr_pkg for field widths.
interface tmcr_item_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [tmcr_pkg::ADDR_W-1:0] address;
    logic [7:0]                  data_char;
    logic [7:0]                  data_attr;
    logic [7:0]                  pending_frames;

    modport source (output valid, mode, address, data_char, data_attr, pending_frames,
                    input ready);
    modport sink   (input valid, mode, address, data_char, data_attr, pending_frames,
                    output ready);
endinterface

interface tmcr_result_if;
    logic                          valid;
    logic                          ready;
    logic [tmcr_pkg::PIXELS_W-1:0] pixels;
    logic [tmcr_pkg::COUNT_W-1:0]  pixel_count;
    logic                          frame_done;
    logic                          clear_pending;

    modport source (output valid, pixels, pixel_count, frame_done, clear_pending,
                    input ready);
    modport sink   (input valid, pixels, pixel_count, frame_done, clear_pending,
                    output ready);
endinterface

[hdl/tmcr_scan_ctrl.sv]
// Input stage: config registers, scan position, blink phase, skip and clip window.
// Depends on tmcr_pkg and tmcr_item_if.
module tmcr_scan_ctrl #(
    parameter int TEXT_COLS          = tmcr_pkg::TEXT_COLS_DEF,
    parameter int TEXT_ROWS          = tmcr_pkg::TEXT_ROWS_DEF,
    parameter int GLYPH_LINES        = tmcr_pkg::GLYPH_LINES_DEF,
    parameter int OUTPUT_PIXEL_LIMIT = tmcr_pkg::OUTPUT_PIXEL_LIMIT_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    tmcr_item_if.sink                                         item,
    input  logic                                              cfg_we,
    input  logic [tmcr_pkg::CFG_IDX_W-1:0]                    cfg_index,
    input  logic [tmcr_pkg::CFG_DATA_W-1:0]                   cfg_data,
    input  logic                                              down_free,
    output logic                                              s1_valid,
    output tmcr_pkg::pix_ctrl_t                               s1_ctrl,
    output logic [tmcr_pkg::ADDR_W-1:0]                       s1_address,
    output logic [7:0]                                        s1_data_char,
    output logic [7:0]                                        s1_data_attr,
    output logic [tmcr_pkg::idx_w(TEXT_COLS*TEXT_ROWS)-1:0]   s1_scr_addr,
    output logic [tmcr_pkg::idx_w(GLYPH_LINES)-1:0]           s1_line
);

    localparam int COL_W  = tmcr_pkg::idx_w(TEXT_COLS);
    localparam int ROW_W  = tmcr_pkg::idx_w(TEXT_ROWS);
    localparam int LINE_W = tmcr_pkg::idx_w(GLYPH_LINES);
    localparam int SCR_AW = tmcr_pkg::idx_w(TEXT_COLS*TEXT_ROWS);
    localparam int PIX_W  = $clog2(OUTPUT_PIXEL_LIMIT + 1);
    localparam int CMP_W  = (PIX_W > tmcr_pkg::COUNT_W) ? PIX_W : tmcr_pkg::COUNT_W;
    localparam int SKIP_W = tmcr_pkg::SKIP_W;

    logic [SKIP_W-1:0] scroll_skip_reg;
    logic [7:0]        cursor_col_reg;
    logic [7:0]        cursor_row_reg;
    logic [7:0]        cursor_first_reg;
    logic [7:0]        cursor_last_reg;
    logic [7:0]        blink_factor_reg;

    logic [COL_W-1:0]  col_reg,   col_next;
    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [LINE_W-1:0] line_reg,  line_next;
    logic              phase_reg, phase_next;
    logic [SKIP_W-1:0] skip_reg,  skip_next;
    logic [PIX_W-1:0]  opi_reg,   opi_next;
    logic              v1_reg;

    tmcr_pkg::pix_ctrl_t       ctrl1_reg, ctrl1_next;
    logic [tmcr_pkg::ADDR_W-1:0] addr1_reg;
    logic [7:0]                char1_reg;
    logic [7:0]                attr1_reg;
    logic [SCR_AW-1:0]         scr1_reg, scr1_next;
    logic [LINE_W-1:0]         line1_reg;

    tmcr_pkg::mode_t          mode;
    logic                     accept;
    logic                     last_col, last_line, last_row;
    logic                     toggled, cursor_here, drop;
    logic [2:0]               start;
    logic [tmcr_pkg::COUNT_W-1:0] avail, take;
    logic [CMP_W-1:0]         remain;

    assign item.ready = !v1_reg || down_free;
    assign accept     = item.valid && item.ready;
    assign mode       = tmcr_pkg::mode_t'(item.mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_skip_reg  <= tmcr_pkg::SCROLL_SKIP_RST;
            cursor_col_reg   <= tmcr_pkg::CURSOR_COL_RST;
            cursor_row_reg   <= tmcr_pkg::CURSOR_ROW_RST;
            cursor_first_reg <= tmcr_pkg::CURSOR_FIRST_RST;
            cursor_last_reg  <= tmcr_pkg::CURSOR_LAST_RST;
            blink_factor_reg <= tmcr_pkg::BLINK_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            case (tmcr_pkg::cfg_index_t'(cfg_index))
                tmcr_pkg::CFG_SCROLL_SKIP:  scroll_skip_reg  <= cfg_data;
                tmcr_pkg::CFG_CURSOR_COL:   cursor_col_reg   <= cfg_data[7:0];
                tmcr_pkg::CFG_CURSOR_ROW:   cursor_row_reg   <= cfg_data[7:0];
                tmcr_pkg::CFG_CURSOR_FIRST: cursor_first_reg <= cfg_data[7:0];
                tmcr_pkg::CFG_CURSOR_LAST:  cursor_last_reg  <= cfg_data[7:0];
                tmcr_pkg::CFG_BLINK_FACTOR: blink_factor_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        last_col  = col_reg  == COL_W'(TEXT_COLS - 1);
        last_line = line_reg == LINE_W'(GLYPH_LINES - 1);
        last_row  = row_reg  == ROW_W'(TEXT_ROWS - 1);
        toggled   = item.pending_frames >= blink_factor_reg;

        cursor_here = phase_reg
            && ({1'b0, cursor_col_reg} == 9'(col_reg) + 9'd1)
            && ({1'b0, cursor_row_reg} == 9'(row_reg) + 9'd1)
            && (8'(line_reg) >= cursor_first_reg)
            && (8'(line_reg) <= cursor_last_reg);

        drop   = skip_reg >= SKIP_W'(tmcr_pkg::CELL_WIDTH);
        start  = drop ? 3'd0 : skip_reg[2:0];
        avail  = tmcr_pkg::COUNT_W'(tmcr_pkg::CELL_WIDTH) - {1'b0, start};
        remain = CMP_W'(PIX_W'(OUTPUT_PIXEL_LIMIT) - opi_reg);
        if (drop)
            take = '0;
        else if (remain < CMP_W'(avail))
            take = tmcr_pkg::COUNT_W'(remain);
        else
            take = avail;

        scr1_next = SCR_AW'(int'(row_reg) * TEXT_COLS + int'(col_reg));

        col_next   = col_reg;
        row_next   = row_reg;
        line_next  = line_reg;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        opi_next   = opi_reg;

        ctrl1_next.mode          = mode;
        ctrl1_next.cursor_here   = cursor_here;
        ctrl1_next.start         = start;
        ctrl1_next.count         = '0;
        ctrl1_next.frame_done    = 1'b0;
        ctrl1_next.clear_pending = 1'b0;

        if (accept)
        begin
            case (mode)
                tmcr_pkg::MODE_FRAME:
                begin
                    phase_next = phase_reg ^ toggled;
                    col_next   = '0;
                    row_next   = '0;
                    line_next  = '0;
                    skip_next  = scroll_skip_reg;
                    opi_next   = '0;
                    ctrl1_next.clear_pending = toggled;
                end
                tmcr_pkg::MODE_RENDER:
                begin
                    col_next = last_col ? '0 : col_reg + COL_W'(1);
                    if (last_col)
                        line_next = last_line ? '0 : line_reg + LINE_W'(1);
                    if (last_col && last_line)
                        row_next = last_row ? '0 : row_reg + ROW_W'(1);
                    skip_next = drop ? skip_reg - SKIP_W'(tmcr_pkg::CELL_WIDTH) : '0;
                    opi_next  = opi_reg + PIX_W'(take);
                    ctrl1_next.count      = take;
                    ctrl1_next.frame_done = last_col && last_line && last_row;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            line_reg  <= '0;
            phase_reg <= 1'b0;
            skip_reg  <= '0;
            opi_reg   <= '0;
            v1_reg    <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            line_reg  <= line_next;
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            opi_reg   <= opi_next;
            if (item.ready)
                v1_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl1_reg <= ctrl1_next;
            addr1_reg <= item.address;
            char1_reg <= item.data_char;
            attr1_reg <= item.data_attr;
            scr1_reg  <= scr1_next;
            line1_reg <= line_reg;
        end
    end

    assign s1_valid     = v1_reg;
    assign s1_ctrl      = ctrl1_reg;
    assign s1_address   = addr1_reg;
    assign s1_data_char = char1_reg;
    assign s1_data_attr = attr1_reg;
    assign s1_scr_addr  = scr1_reg;
    assign s1_line      = line1_reg;

endmodule

[hdl/tmcr_glyph_fetch.sv]
// Screen cell memory and font memory, read in two registered stages.
// Depends on tmcr_pkg.
module tmcr_glyph_fetch #(
    parameter int TEXT_COLS   = tmcr_pkg::TEXT_COLS_DEF,
    parameter int TEXT_ROWS   = tmcr_pkg::TEXT_ROWS_DEF,
    parameter int GLYPH_LINES = tmcr_pkg::GLYPH_LINES_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s1_valid,
    input  tmcr_pkg::pix_ctrl_t                             s1_ctrl,
    input  logic [tmcr_pkg::ADDR_W-1:0]                     s1_address,
    input  logic [7:0]                                      s1_data_char,
    input  logic [7:0]                                      s1_data_attr,
    input  logic [tmcr_pkg::idx_w(TEXT_COLS*TEXT_ROWS)-1:0] s1_scr_addr,
    input  logic [tmcr_pkg::idx_w(GLYPH_LINES)-1:0]         s1_line,
    output logic                                            s1_free,
    output logic                                            s3_valid,
    output tmcr_pkg::pix_ctrl_t                             s3_ctrl,
    output logic [7:0]                                      s3_bits,
    output logic [7:0]                                      s3_attr,
    input  logic                                            out_free
);

    localparam int CELLS  = TEXT_COLS * TEXT_ROWS;
    localparam int SCR_AW = tmcr_pkg::idx_w(CELLS);
    localparam int LINE_W = tmcr_pkg::idx_w(GLYPH_LINES);

    logic [15:0] screen_mem [CELLS];
    logic [7:0]  font_mem   [tmcr_pkg::FONT_DEPTH];

    logic                        v2_reg, v3_reg;
    tmcr_pkg::pix_ctrl_t         ctrl2_reg, ctrl3_reg;
    logic [tmcr_pkg::ADDR_W-1:0] addr2_reg;
    logic [7:0]                  char2_reg;
    logic [LINE_W-1:0]           line2_reg;
    logic [15:0]                 cell_q_reg;
    logic [7:0]                  font_q_reg;
    logic [7:0]                  attr3_reg;

    logic                         f2, f3;
    logic                         screen_we, font_we;
    logic [tmcr_pkg::FONT_AW-1:0] font_addr;

    assign f3      = !v3_reg || out_free;
    assign f2      = !v2_reg || f3;
    assign s1_free = f2;

    assign screen_we = s1_valid && (s1_ctrl.mode == tmcr_pkg::MODE_SCREEN_WR)
                       && (int'(s1_address) < CELLS);
    assign font_we   = v2_reg && (ctrl2_reg.mode == tmcr_pkg::MODE_FONT_WR);
    assign font_addr = tmcr_pkg::FONT_AW'(int'(cell_q_reg[7:0]) * GLYPH_LINES
                                          + int'(line2_reg));

    always_ff @(posedge clk)
    begin
        if (f2)
        begin
            if (screen_we)
                screen_mem[SCR_AW'(s1_address)] <= {s1_data_attr, s1_data_char};
            cell_q_reg <= screen_mem[s1_scr_addr];
            ctrl2_reg  <= s1_ctrl;
            addr2_reg  <= s1_address;
            char2_reg  <= s1_data_char;
            line2_reg  <= s1_line;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f3)
        begin
            if (font_we)
                font_mem[addr2_reg] <= char2_reg;
            font_q_reg <= font_mem[font_addr];
            ctrl3_reg  <= ctrl2_reg;
            attr3_reg  <= cell_q_reg[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (f2)
                v2_reg <= s1_valid;
            if (f3)
                v3_reg <= v2_reg;
        end
    end

    assign s3_valid = v3_reg;
    assign s3_ctrl  = ctrl3_reg;
    assign s3_bits  = font_q_reg;
    assign s3_attr  = attr3_reg;

endmodule

[hdl/tmcr_pixel_out.sv]
// Pixel packing (cursor, colors, skip window) into the result register.
// Depends on tmcr_pkg and tmcr_result_if.
module tmcr_pixel_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s3_valid,
    input  tmcr_pkg::pix_ctrl_t s3_ctrl,
    input  logic [7:0]          s3_bits,
    input  logic [7:0]          s3_attr,
    output logic                out_free,
    tmcr_result_if.source       result
);

    logic                            out_v_reg;
    logic [tmcr_pkg::PIXELS_W-1:0]   pixels_reg, pixels_next;
    logic [tmcr_pkg::COUNT_W-1:0]    count_reg;
    logic                            done_reg;
    logic                            clear_reg;

    logic [3:0] fg, bg;
    logic [3:0] colour [8];
    logic       has_result;

    assign out_free   = !out_v_reg || result.ready;
    assign has_result = (s3_ctrl.mode == tmcr_pkg::MODE_RENDER)
                        || (s3_ctrl.mode == tmcr_pkg::MODE_FRAME);
    assign fg = s3_attr[3:0];
    assign bg = s3_attr[7:4];

    always_comb
    begin
        for (int p = 0; p < 8; p++)
            colour[p] = (s3_ctrl.cursor_here || s3_bits[7 - p]) ? fg : bg;
        pixels_next = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (tmcr_pkg::COUNT_W'(j) < s3_ctrl.count)
                pixels_next[4*j +: 4] = colour[3'(int'(s3_ctrl.start) + j)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_free)
            out_v_reg <= s3_valid && has_result;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            pixels_reg <= pixels_next;
            count_reg  <= s3_ctrl.count;
            done_reg   <= s3_ctrl.frame_done;
            clear_reg  <= s3_ctrl.clear_pending;
        end
    end

    assign result.valid         = out_v_reg;
    assign result.pixels        = pixels_reg;
    assign result.pixel_count   = count_reg;
    assign result.frame_done    = done_reg;
    assign result.clear_pending = clear_reg;

endmodule

[hdl/text_mode_character_renderer.sv]
// Text mode character renderer, top level.
// An accepted transaction passes the scan, screen read, font read and result registers.
// Throughput: one transaction per cycle while result.ready does not stall the output.
// Store writes and frame starts take one slot each; only writes give no result.
// Reset clears position, blink phase and pipeline valids and loads the config registers
// with their defaults; font and screen memories hold no reset value.
module text_mode_character_renderer #(
    parameter int TEXT_COLS          = tmcr_pkg::TEXT_COLS_DEF,
    parameter int TEXT_ROWS          = tmcr_pkg::TEXT_ROWS_DEF,
    parameter int GLYPH_LINES        = tmcr_pkg::GLYPH_LINES_DEF,
    parameter int OUTPUT_PIXEL_LIMIT = tmcr_pkg::OUTPUT_PIXEL_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tmcr_item_if.sink                       item,
    tmcr_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [tmcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmcr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SCR_AW = tmcr_pkg::idx_w(TEXT_COLS*TEXT_ROWS);
    localparam int LINE_W = tmcr_pkg::idx_w(GLYPH_LINES);

    logic                        s1_valid, s1_free;
    tmcr_pkg::pix_ctrl_t         s1_ctrl;
    logic [tmcr_pkg::ADDR_W-1:0] s1_address;
    logic [7:0]                  s1_data_char, s1_data_attr;
    logic [SCR_AW-1:0]           s1_scr_addr;
    logic [LINE_W-1:0]           s1_line;

    logic                        s3_valid, out_free;
    tmcr_pkg::pix_ctrl_t         s3_ctrl;
    logic [7:0]                  s3_bits, s3_attr;

    tmcr_scan_ctrl #(
        .TEXT_COLS          (TEXT_COLS),
        .TEXT_ROWS          (TEXT_ROWS),
        .GLYPH_LINES        (GLYPH_LINES),
        .OUTPUT_PIXEL_LIMIT (OUTPUT_PIXEL_LIMIT)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .down_free    (s1_free),
        .s1_valid     (s1_valid),
        .s1_ctrl      (s1_ctrl),
        .s1_address   (s1_address),
        .s1_data_char (s1_data_char),
        .s1_data_attr (s1_data_attr),
        .s1_scr_addr  (s1_scr_addr),
        .s1_line      (s1_line)
    );

    tmcr_glyph_fetch #(
        .TEXT_COLS   (TEXT_COLS),
        .TEXT_ROWS   (TEXT_ROWS),
        .GLYPH_LINES (GLYPH_LINES)
    ) u_fetch (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ctrl      (s1_ctrl),
        .s1_address   (s1_address),
        .s1_data_char (s1_data_char),
        .s1_data_attr (s1_data_attr),
        .s1_scr_addr  (s1_scr_addr),
        .s1_line      (s1_line),
        .s1_free      (s1_free),
        .s3_valid     (s3_valid),
        .s3_ctrl      (s3_ctrl),
        .s3_bits      (s3_bits),
        .s3_attr      (s3_attr),
        .out_free     (out_free)
    );

    tmcr_pixel_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s3_valid (s3_valid),
        .s3_ctrl  (s3_ctrl),
        .s3_bits  (s3_bits),
        .s3_attr  (s3_attr),
        .out_free (out_free),
        .result   (result)
    );

endmodule

[hdl/tmcr_checker.sv]
// Port-level assertions for the text mode character renderer, bound to the top level.
// Depends on tmcr_pkg and text_mode_character_renderer.
module tmcr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [tmcr_pkg::PIXELS_W-1:0] pixels,
    input logic [tmcr_pkg::COUNT_W-1:0]  pixel_count,
    input logic                          frame_done,
    input logic                          clear_pending
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(pixels) && $stable(pixel_count)
                                    && $stable(frame_done) && $stable(clear_pending))
        else $error("stalled result changed");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && clear_pending |-> pixel_count == '0 && pixels == '0 && !frame_done)
        else $error("frame start result carries pixels");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pixel_count <= tmcr_pkg::COUNT_W'(tmcr_pkg::CELL_WIDTH))
        else $error("pixel count above cell width");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && pixel_count == '0 |-> pixels == '0)
        else $error("empty result with nonzero pixels");

endmodule

bind text_mode_character_renderer tmcr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .pixels        (result.pixels),
    .pixel_count   (result.pixel_count),
    .frame_done    (result.frame_done),
    .clear_pending (result.clear_pending)
);
